/* src/usbp_pkg.sv */
`default_nettype none

package usbp_pkg;

  typedef logic [5:0] phase_t;

  // field kinds double as parse phases; phases above the verdict are internal
  localparam phase_t K_TICK       = 6'd0;
  localparam phase_t K_INDEX      = 6'd1;
  localparam phase_t K_TYPE       = 6'd2;
  localparam phase_t K_KIND       = 6'd3;
  localparam phase_t K_FLAGS      = 6'd4;
  localparam phase_t K_UNK        = 6'd5;
  localparam phase_t K_ATT        = 6'd6;
  localparam phase_t K_TOL        = 6'd7;
  localparam phase_t K_ALT        = 6'd8;
  localparam phase_t K_HOFF       = 6'd9;
  localparam phase_t K_GX         = 6'd10;
  localparam phase_t K_GY         = 6'd11;
  localparam phase_t K_GZ         = 6'd12;
  localparam phase_t K_HASH       = 6'd13;
  localparam phase_t K_MX         = 6'd14;
  localparam phase_t K_MY         = 6'd15;
  localparam phase_t K_MZ         = 6'd16;
  localparam phase_t K_VX         = 6'd17;
  localparam phase_t K_VY         = 6'd18;
  localparam phase_t K_VZ         = 6'd19;
  localparam phase_t K_HEAD       = 6'd20;
  localparam phase_t K_MODE       = 6'd21;
  localparam phase_t K_BLOCKED    = 6'd22;
  localparam phase_t K_COUNT      = 6'd23;
  localparam phase_t K_WX         = 6'd24;
  localparam phase_t K_WZ         = 6'd25;
  localparam phase_t K_END        = 6'd26;
  localparam phase_t K_STYPE      = 6'd27;
  localparam phase_t K_HEALTH     = 6'd28;
  localparam phase_t K_BUILD      = 6'd29;
  localparam phase_t K_SFLAGS     = 6'd30;
  localparam phase_t K_MOTION     = 6'd31;
  localparam phase_t K_CARRIER    = 6'd32;
  localparam phase_t K_PIECE      = 6'd33;
  localparam phase_t K_PX         = 6'd34;
  localparam phase_t K_PY         = 6'd35;
  localparam phase_t K_PZ         = 6'd36;
  localparam phase_t K_RY         = 6'd37;
  localparam phase_t K_RZ         = 6'd38;
  localparam phase_t K_RX         = 6'd39;
  localparam phase_t K_SPEED      = 6'd40;
  localparam phase_t K_VERDICT    = 6'd41;
  localparam phase_t PH_HEADER    = 6'd42;
  localparam phase_t PH_SYNCFLAG  = 6'd43;
  localparam phase_t PH_CARRYFLAG = 6'd44;
  localparam phase_t PH_DONE      = 6'd45;
  localparam phase_t PH_SKIP      = 6'd46;

  localparam logic [15:0] END_INDEX = 16'hffff;
  localparam logic [8:0]  MAX_TYPES = 9'd256;

  localparam logic [7:0] GF_UNK  = 8'h01;
  localparam logic [7:0] GF_TOL  = 8'h10;
  localparam logic [7:0] GF_ALT  = 8'h08;
  localparam logic [7:0] GF_HOFF = 8'h40;
  localparam logic [7:0] GF_GOAL = 8'h20;

  typedef enum logic [3:0] {
    CFG_CODE  = 4'd0,
    CFG_TBITS = 4'd1,
    CFG_TSIZE = 4'd2,
    CFG_SLOTS = 4'd3,
    CFG_FLY0  = 4'd4,
    CFG_FLY1  = 4'd5,
    CFG_FLY2  = 4'd6,
    CFG_FLY3  = 4'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BITS,
    ST_DIV,
    ST_VERDICT
  } seq_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  field_kind;
    logic [31:0] field_value;
    logic [15:0] unit_slot;
    logic        parse_error;
    logic        last_of_packet;
  } out_item_t;

  function automatic logic [5:0] phase_width(phase_t ph, logic [3:0] tbits);
    logic [5:0] w;
    w = 6'd0;
    case (ph) inside
      K_TICK, K_GX, K_GY, K_GZ, K_MX, K_MY, K_MZ, K_VX, K_VY, K_VZ,
      K_PX, K_PY, K_PZ, K_SPEED: w = 6'd32;
      K_INDEX, K_UNK, K_ATT, K_TOL, K_ALT, K_HOFF, K_HEAD, K_WX, K_WZ,
      K_HEALTH, K_RY, K_RZ, K_RX: w = 6'd16;
      K_FLAGS, K_BUILD, K_SFLAGS, K_PIECE: w = 6'd8;
      K_KIND, K_MODE, K_COUNT, K_MOTION: w = 6'd2;
      K_HASH, K_BLOCKED, PH_SYNCFLAG, PH_CARRYFLAG: w = 6'd1;
      K_CARRIER: w = 6'd15;
      K_TYPE, K_STYPE: w = {2'b00, tbits};
      default: w = 6'd0;
    endcase
    return w;
  endfunction

  function automatic phase_t goal_from(logic [2:0] stage, logic [7:0] gf);
    phase_t p;
    if (stage < 3'd1 && (gf & GF_UNK) != 8'd0) p = K_UNK;
    else if (stage < 3'd2 && (gf & GF_TOL) != 8'd0) p = K_TOL;
    else if (stage < 3'd3 && (gf & GF_ALT) != 8'd0) p = K_ALT;
    else if (stage < 3'd4 && (gf & GF_HOFF) != 8'd0) p = K_HOFF;
    else if (stage < 3'd5 && (gf & GF_GOAL) != 8'd0) p = K_GX;
    else p = K_MODE;
    return p;
  endfunction

  function automatic logic [31:0] shown_value(phase_t ph, logic [31:0] v);
    logic [31:0] s;
    s = v;
    case (ph) inside
      K_UNK, K_TOL, K_ALT, K_HOFF, K_WX, K_WZ, K_RY, K_RZ, K_RX:
        s = {{16{v[15]}}, v[15:0]};
      K_PIECE: s = {{24{v[7]}}, v[7:0]};
      default: s = v;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

/* src/usbp_rem.sv */
`default_nettype none

module usbp_rem
  import usbp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [15:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [15:0]      rem_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] num_q, num_d;
  logic [15:0] rem_q, rem_d;
  logic [16:0] shifted;
  logic [16:0] diff;

  // restoring remainder, one dividend bit a cycle
  always_comb begin
    shifted = {rem_q, num_q[31]};
    diff    = shifted - {1'b0, divisor_i};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    num_d   = num_q;
    rem_d   = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 5'd0;
      num_d  = dividend_i;
      rem_d  = 16'd0;
    end else if (busy_q) begin
      num_d = {num_q[30:0], 1'b0};
      rem_d = (shifted >= {1'b0, divisor_i}) ? diff[15:0] : shifted[15:0];
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

/* src/unit_state_bitstream_parser_core.sv */
`default_nettype none

// Unit state subpacket parser. One byte is taken per input transfer and its
// bits are read LSB first, one bit a cycle while the output register is free,
// through a single field accumulator; each decoded field but the sync and
// carrier flags leaves as one output transfer, and the byte flagged as end of
// packet adds a verdict transfer. A new byte is taken only in the idle state,
// once the last one is through. The sync unit index (tick modulo unit_slots)
// comes from a serial remainder unit that runs on the byte that holds the
// sync flag.
module unit_state_bitstream_parser_core
  import usbp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_item_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_item_t        out_data_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [3:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);

  seq_e state_q, state_d;

  logic [7:0]       code_q;
  logic [3:0]       tbits_q;
  logic [8:0]       tsize_q;
  logic [15:0]      slots_q;
  logic [3:0][63:0] fly_q;

  logic [7:0]  byte_q, byte_d;
  logic        eop_q, eop_d;
  logic [2:0]  bit_q, bit_d;
  logic [15:0] idx_q, idx_d;
  logic        more_q, more_d;
  phase_t      phase_q, phase_d;
  logic [31:0] acc_q, acc_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [15:0] bytecnt_q, bytecnt_d;
  logic [15:0] declen_q, declen_d;
  logic [31:0] tick_q, tick_d;
  logic [15:0] unit_q, unit_d;
  logic [7:0]  gflags_q, gflags_d;
  logic [1:0]  wpleft_q, wpleft_d;
  logic        err_q, err_d;
  out_item_t   out_q, out_d;
  logic        out_valid_q, out_valid_d;

  logic        out_free, in_xfer;
  logic        full, len_over, go_bits;
  logic        cur_bit, stop, wfail, fin;
  logic [5:0]  wid, cnt_new;
  logic [31:0] acc_new;
  logic [8:0]  tsize;
  logic        type_ok, fly_bit, speed_ok;
  logic [1:0]  wp_dec;
  logic        c_emit, c_fail, c_div;
  out_item_t   c_item;
  phase_t      c_next;
  logic        div_start, div_busy, div_done;
  logic [15:0] div_rem;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // byte level checks
  assign full     = (bytecnt_q == END_INDEX);
  assign len_over = ({1'b0, bytecnt_q} + 17'd1) > {1'b0, declen_q};
  assign go_bits  = !full && phase_q != PH_HEADER && phase_q != PH_DONE &&
                    phase_q != PH_SKIP && !len_over;

  // one bit step
  assign cur_bit  = byte_q[bit_q];
  assign wid      = phase_width(phase_q, tbits_q);
  assign stop     = (phase_q == PH_DONE) || (phase_q == PH_SKIP);
  assign wfail    = !stop && (wid == 6'd0);
  assign acc_new  = acc_q | ({31'd0, cur_bit} << cnt_q[4:0]);
  assign cnt_new  = cnt_q + 6'd1;
  assign fin      = !stop && !wfail && (cnt_new >= wid);
  assign tsize    = (tsize_q > MAX_TYPES) ? MAX_TYPES : tsize_q;
  assign type_ok  = (acc_new != 32'd0) && (acc_new < {23'd0, tsize});
  assign fly_bit  = fly_q[acc_new[7:6]][acc_new[5:0]];
  assign speed_ok = {1'b0, declen_q, 3'b000} >=
                    ({1'b0, idx_q, 3'b000} + {17'd0, bit_q} + 20'd33);
  assign wp_dec   = wpleft_q - 2'd1;

  always_comb begin
    c_emit = 1'b1;
    c_fail = 1'b0;
    c_div  = 1'b0;
    c_next = phase_q + 6'd1;
    c_item = '{field_kind: phase_q, field_value: shown_value(phase_q, acc_new),
               unit_slot: unit_q, parse_error: 1'b0, last_of_packet: 1'b0};
    case (phase_q)
      K_TICK: begin
        c_item.unit_slot = 16'd0;
        c_next = K_INDEX;
      end
      K_INDEX: begin
        if (acc_new[15:0] == END_INDEX) begin
          c_item.field_kind = K_END;
          c_item.unit_slot  = 16'd0;
          c_next = PH_SYNCFLAG;
        end else begin
          c_item.unit_slot = acc_new[15:0];
          c_next = K_TYPE;
        end
      end
      K_TYPE: begin
        c_fail = !type_ok;
        c_next = fly_bit ? K_KIND : K_BLOCKED;
      end
      K_KIND: begin
        case (acc_new[1:0])
          2'd0: c_next = K_MODE;
          2'd1: c_next = K_FLAGS;
          2'd2: c_next = K_HASH;
          default: c_fail = 1'b1;
        endcase
      end
      K_FLAGS: c_next = goal_from(3'd0, acc_new[7:0]);
      K_ATT:   c_next = goal_from(3'd1, gflags_q);
      K_TOL:   c_next = goal_from(3'd2, gflags_q);
      K_ALT:   c_next = goal_from(3'd3, gflags_q);
      K_HOFF:  c_next = goal_from(3'd4, gflags_q);
      K_GZ:    c_next = K_MODE;
      K_HASH:  c_next = K_MX;
      K_VZ:    c_next = gflags_q[0] ? K_HEAD : K_MODE;
      K_HEAD:  c_next = K_MODE;
      K_MODE:  c_next = K_INDEX;
      K_COUNT: c_next = (acc_new[1:0] != 2'd0) ? K_WX : K_INDEX;
      K_WZ:    c_next = (wp_dec != 2'd0) ? K_WX : K_INDEX;
      PH_SYNCFLAG: begin
        c_emit = 1'b0;
        c_div  = acc_new[0] && (slots_q != 16'd0);
        c_next = acc_new[0] ? K_STYPE : PH_DONE;
      end
      K_STYPE: begin
        if (acc_new == 32'd0) c_next = PH_DONE;
        else if (!type_ok) c_fail = 1'b1;
        else c_next = K_HEALTH;
      end
      K_MOTION: c_next = PH_CARRYFLAG;
      PH_CARRYFLAG: begin
        c_emit = 1'b0;
        c_next = acc_new[0] ? K_CARRIER : K_PX;
      end
      K_PIECE: c_next = PH_DONE;
      K_RX:    c_next = speed_ok ? K_SPEED : PH_DONE;
      K_SPEED: c_next = PH_DONE;
      default: c_next = phase_q + 6'd1;
    endcase
  end

  assign div_start = (state_q == ST_BITS) && out_free && fin && c_div;

  usbp_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (tick_q),
    .divisor_i  (slots_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (go_bits) state_d = ST_BITS;
          else if (in_data_i.end_of_packet) state_d = ST_VERDICT;
        end
      end
      ST_BITS: begin
        if (out_free) begin
          if (stop || wfail || (fin && c_fail) || (!(fin && c_div) && bit_q == 3'd7)) begin
            state_d = eop_q ? ST_VERDICT : ST_IDLE;
          end else if (fin && c_div) begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) state_d = more_q ? ST_BITS : (eop_q ? ST_VERDICT : ST_IDLE);
      end
      ST_VERDICT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    byte_d      = byte_q;
    eop_d       = eop_q;
    bit_d       = bit_q;
    idx_d       = idx_q;
    more_d      = more_q;
    phase_d     = phase_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    bytecnt_d   = bytecnt_q;
    declen_d    = declen_q;
    tick_d      = tick_q;
    unit_d      = unit_q;
    gflags_d    = gflags_q;
    wpleft_d    = wpleft_q;
    err_d       = err_q;
    out_d       = out_q;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          byte_d = in_data_i.data_byte;
          eop_d  = in_data_i.end_of_packet;
          bit_d  = 3'd0;
          idx_d  = bytecnt_q;
          if (full) begin
            err_d   = 1'b1;
            phase_d = PH_SKIP;
          end else begin
            bytecnt_d = bytecnt_q + 16'd1;
            if (phase_q == PH_HEADER) begin
              if (bytecnt_q == 16'd0) begin
                if (in_data_i.data_byte != code_q || tbits_q == 4'd0 ||
                    slots_q == 16'd0) begin
                  err_d   = 1'b1;
                  phase_d = PH_SKIP;
                end
              end else if (bytecnt_q == 16'd1) begin
                declen_d = {8'd0, in_data_i.data_byte};
              end else begin
                declen_d = {in_data_i.data_byte, declen_q[7:0]};
                phase_d  = K_TICK;
              end
            end else if (phase_q == PH_DONE) begin
              err_d   = 1'b1;
              phase_d = PH_SKIP;
            end else if (phase_q != PH_SKIP && len_over) begin
              err_d   = 1'b1;
              phase_d = PH_SKIP;
            end
          end
        end
      end
      ST_BITS: begin
        if (out_free && !stop) begin
          bit_d  = bit_q + 3'd1;
          more_d = (bit_q != 3'd7);
          if (wfail) begin
            err_d   = 1'b1;
            phase_d = PH_SKIP;
          end else if (fin) begin
            acc_d = 32'd0;
            cnt_d = 6'd0;
            if (c_emit) begin
              out_d       = c_item;
              out_valid_d = 1'b1;
            end
            if (phase_q == K_TICK) tick_d = acc_new;
            if (phase_q == K_INDEX && acc_new[15:0] != END_INDEX) unit_d = acc_new[15:0];
            if (phase_q == K_FLAGS) gflags_d = acc_new[7:0];
            if (phase_q == K_HASH) gflags_d = {7'd0, acc_new[0]};
            if (phase_q == K_COUNT) wpleft_d = acc_new[1:0];
            if (phase_q == K_WZ) wpleft_d = wp_dec;
            if (phase_q == PH_SYNCFLAG && acc_new[0] && slots_q == 16'd0) unit_d = 16'd0;
            if (c_fail) begin
              err_d   = 1'b1;
              phase_d = PH_SKIP;
            end else begin
              phase_d = c_next;
            end
          end else begin
            acc_d = acc_new;
            cnt_d = cnt_new;
          end
        end
      end
      ST_DIV: begin
        if (div_done) unit_d = div_rem;
      end
      ST_VERDICT: begin
        if (out_free) begin
          out_d = '{field_kind: K_VERDICT, field_value: 32'd0, unit_slot: 16'd0,
                    parse_error: err_q || phase_q != PH_DONE || bytecnt_q != declen_q,
                    last_of_packet: 1'b1};
          out_valid_d = 1'b1;
          phase_d     = PH_HEADER;
          acc_d       = 32'd0;
          cnt_d       = 6'd0;
          bytecnt_d   = 16'd0;
          declen_d    = 16'd0;
          tick_d      = 32'd0;
          unit_d      = 16'd0;
          gflags_d    = 8'd0;
          wpleft_d    = 2'd0;
          err_d       = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_HEADER;
      acc_q       <= 32'd0;
      cnt_q       <= 6'd0;
      bytecnt_q   <= 16'd0;
      declen_q    <= 16'd0;
      tick_q      <= 32'd0;
      unit_q      <= 16'd0;
      gflags_q    <= 8'd0;
      wpleft_q    <= 2'd0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
      bit_q       <= 3'd0;
      more_q      <= 1'b0;
      eop_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      bytecnt_q   <= bytecnt_d;
      declen_q    <= declen_d;
      tick_q      <= tick_d;
      unit_q      <= unit_d;
      gflags_q    <= gflags_d;
      wpleft_q    <= wpleft_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
      bit_q       <= bit_d;
      more_q      <= more_d;
      eop_q       <= eop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    idx_q  <= idx_d;
    out_q  <= out_d;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q  <= 8'd0;
      tbits_q <= 4'd0;
      tsize_q <= 9'd1;
      slots_q <= 16'd0;
      fly_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_CODE:  code_q  <= cfg_data_i[7:0];
        CFG_TBITS: tbits_q <= cfg_data_i[3:0];
        CFG_TSIZE: tsize_q <= cfg_data_i[8:0];
        CFG_SLOTS: slots_q <= cfg_data_i[15:0];
        CFG_FLY0, CFG_FLY1, CFG_FLY2, CFG_FLY3: fly_q[cfg_index_i[1:0]] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_last_is_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last_of_packet == (out_data_o.field_kind == K_VERDICT)))
    else $error("last flag and verdict kind disagree");

  a_error_on_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.parse_error) |-> out_data_o.last_of_packet)
    else $error("error flag outside verdict");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PH_SKIP)
    else $error("parse phase out of range");

  a_div_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_busy || div_done) |-> state_q == ST_DIV)
    else $error("remainder unit active outside wait state");
`endif

endmodule

`default_nettype wire

/* tb/tb.sv */
`default_nettype none

module tb;
  import usbp_pkg::*;

  localparam int LIMIT = 1500000;

  typedef struct {
    logic [7:0] b;
    bit         eop;
    bit         typed;
    bit         terr;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  unit_state_bitstream_parser_core dut (.*);

  always #10 clk_i = ~clk_i;

  // register copies
  logic [7:0]  r_code;
  logic [3:0]  r_tbits;
  logic [8:0]  r_tsize;
  logic [15:0] r_slots;
  logic [63:0] r_fly [4];

  // packet parse state
  phase_t      ph;
  logic [31:0] acc;
  int          nbits;
  int          bcount;
  logic [15:0] dlen;
  logic [31:0] tick;
  logic [15:0] cur;
  logic [7:0]  gflags;
  logic [1:0]  wleft;
  bit          err_l;

  out_item_t   field_q [$];
  out_item_t   byte_fields [$];
  bit          bits_q [$];
  logic [7:0]  pkt_q [$];
  int          n_fail = 0;
  int          cycles = 0;
  int          stall_left = 0;

  function automatic int field_width(phase_t p);
    case (p)
      K_TICK, K_GX, K_GY, K_GZ, K_MX, K_MY, K_MZ, K_VX, K_VY, K_VZ,
      K_PX, K_PY, K_PZ, K_SPEED: return 32;
      K_INDEX, K_UNK, K_ATT, K_TOL, K_ALT, K_HOFF, K_HEAD, K_WX, K_WZ,
      K_HEALTH, K_RY, K_RZ, K_RX: return 16;
      K_FLAGS, K_BUILD, K_SFLAGS, K_PIECE: return 8;
      K_KIND, K_MODE, K_COUNT, K_MOTION: return 2;
      K_HASH, K_BLOCKED, PH_SYNCFLAG, PH_CARRYFLAG: return 1;
      K_CARRIER: return 15;
      K_TYPE, K_STYPE: return int'(r_tbits);
      default: return 0;
    endcase
  endfunction

  function automatic phase_t next_goal(int stage);
    if (stage < 1 && gflags[0]) return K_UNK;
    if (stage < 2 && gflags[4]) return K_TOL;
    if (stage < 3 && gflags[3]) return K_ALT;
    if (stage < 4 && gflags[6]) return K_HOFF;
    if (stage < 5 && gflags[5]) return K_GX;
    return K_MODE;
  endfunction

  task automatic add_field(phase_t k, logic [31:0] v, logic [15:0] u, bit e, bit l);
    out_item_t o;
    o.field_kind = k;
    o.field_value = v;
    o.unit_slot = u;
    o.parse_error = e;
    o.last_of_packet = l;
    byte_fields.push_back(o);
  endtask

  task automatic reject();
    err_l = 1'b1;
    ph = PH_SKIP;
  endtask

  task automatic clear_pkt();
    ph = PH_HEADER;
    acc = '0;
    nbits = 0;
    bcount = 0;
    dlen = '0;
    tick = '0;
    cur = '0;
    gflags = '0;
    wleft = '0;
    err_l = 1'b0;
  endtask

  task automatic field_done(logic [31:0] v, int pos);
    phase_t p;
    phase_t nx;
    int tsz;
    logic [31:0] sv;
    p = ph;
    nx = ph + 6'd1;
    tsz = (r_tsize < 9'd256) ? int'(r_tsize) : 256;
    sv = v;
    if (p inside {K_UNK, K_TOL, K_ALT, K_HOFF, K_WX, K_WZ, K_RY, K_RZ, K_RX})
      sv = {{16{v[15]}}, v[15:0]};
    else if (p == K_PIECE)
      sv = {{24{v[7]}}, v[7:0]};
    if (p == K_INDEX) begin
      if (v[15:0] == END_INDEX) begin
        add_field(K_END, v, '0, 1'b0, 1'b0);
      end else begin
        cur = v[15:0];
        add_field(K_INDEX, v, v[15:0], 1'b0, 1'b0);
      end
    end else if (p == K_TICK) begin
      add_field(K_TICK, v, '0, 1'b0, 1'b0);
    end else if (p != PH_SYNCFLAG && p != PH_CARRYFLAG) begin
      add_field(p, sv, cur, 1'b0, 1'b0);
    end
    case (p)
      K_TICK: begin
        tick = v;
        nx = K_INDEX;
      end
      K_INDEX: nx = (v[15:0] == END_INDEX) ? PH_SYNCFLAG : K_TYPE;
      K_TYPE: begin
        if (v == 0 || v >= tsz) begin
          reject();
          return;
        end
        nx = r_fly[v[7:6]][v[5:0]] ? K_KIND : K_BLOCKED;
      end
      K_KIND: begin
        if (v == 0) nx = K_MODE;
        else if (v == 1) nx = K_FLAGS;
        else if (v == 2) nx = K_HASH;
        else begin
          reject();
          return;
        end
      end
      K_FLAGS: begin
        gflags = v[7:0];
        nx = next_goal(0);
      end
      K_ATT: nx = next_goal(1);
      K_TOL: nx = next_goal(2);
      K_ALT: nx = next_goal(3);
      K_HOFF: nx = next_goal(4);
      K_GZ: nx = K_MODE;
      K_HASH: begin
        gflags = {7'd0, v[0]};
        nx = K_MX;
      end
      K_VZ: nx = gflags[0] ? K_HEAD : K_MODE;
      K_HEAD: nx = K_MODE;
      K_MODE: nx = K_INDEX;
      K_COUNT: begin
        wleft = v[1:0];
        nx = (wleft != 0) ? K_WX : K_INDEX;
      end
      K_WZ: begin
        wleft = wleft - 2'd1;
        nx = (wleft != 0) ? K_WX : K_INDEX;
      end
      PH_SYNCFLAG: begin
        if (v != 0) begin
          cur = (r_slots != 0) ? 16'(tick % r_slots) : 16'd0;
          nx = K_STYPE;
        end else begin
          nx = PH_DONE;
        end
      end
      K_STYPE: begin
        if (v == 0) nx = PH_DONE;
        else if (v >= tsz) begin
          reject();
          return;
        end else nx = K_HEALTH;
      end
      K_MOTION: nx = PH_CARRYFLAG;
      PH_CARRYFLAG: nx = (v != 0) ? K_CARRIER : K_PX;
      K_PIECE: nx = PH_DONE;
      K_RX: nx = (int'(dlen) * 8 >= pos + 32) ? K_SPEED : PH_DONE;
      K_SPEED: nx = PH_DONE;
      default: ;
    endcase
    ph = nx;
  endtask

  task automatic decode_byte(logic [7:0] b, bit eop);
    int idx;
    int w;
    logic [31:0] v;
    byte_fields.delete();
    idx = bcount;
    if (idx >= 'hffff) begin
      reject();
    end else begin
      bcount = idx + 1;
      if (ph == PH_HEADER) begin
        if (idx == 0) begin
          if (b != r_code || r_tbits == 0 || r_slots == 0) reject();
        end else if (idx == 1) begin
          dlen = {8'd0, b};
        end else begin
          dlen[15:8] = b;
          ph = K_TICK;
        end
      end else if (ph == PH_DONE) begin
        reject();
      end else if (ph != PH_SKIP) begin
        if (bcount > dlen) begin
          reject();
        end else begin
          for (int i = 0; i < 8; i++) begin
            if (ph == PH_DONE || ph == PH_SKIP) break;
            w = field_width(ph);
            if (w == 0) begin
              reject();
              break;
            end
            acc[nbits] = b[i];
            nbits++;
            if (nbits >= w) begin
              v = acc;
              acc = '0;
              nbits = 0;
              field_done(v, idx * 8 + i + 1);
            end
          end
        end
      end
    end
    if (eop) begin
      add_field(K_VERDICT, '0, '0,
                err_l || ph != PH_DONE || bcount != int'(dlen), 1'b1);
      clear_pkt();
    end
  endtask

  // output side: random stalls, compare against oldest expected field
  always @(posedge clk_i) begin
    int r;
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (field_q.size() == 0) begin
        $error("unexpected transfer kind %0d", out_data_o.field_kind);
        n_fail++;
      end else begin
        out_item_t e;
        e = field_q.pop_front();
        if (e.field_kind !== out_data_o.field_kind) begin
          $error("field_kind exp %0d got %0d", e.field_kind, out_data_o.field_kind);
          n_fail++;
        end
        if (e.field_value !== out_data_o.field_value) begin
          $error("field_value exp %h got %h", e.field_value, out_data_o.field_value);
          n_fail++;
        end
        if (e.unit_slot !== out_data_o.unit_slot) begin
          $error("unit_slot exp %h got %h", e.unit_slot, out_data_o.unit_slot);
          n_fail++;
        end
        if (e.parse_error !== out_data_o.parse_error) begin
          $error("parse_error exp %0d got %0d", e.parse_error, out_data_o.parse_error);
          n_fail++;
        end
        if (e.last_of_packet !== out_data_o.last_of_packet) begin
          $error("last_of_packet exp %0d got %0d", e.last_of_packet,
                 out_data_o.last_of_packet);
          n_fail++;
        end
      end
    end
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
      r = $urandom_range(0, 99);
      if ((cycles % 2048) > 300) begin
        if (r < 12) stall_left = $urandom_range(1, 3);
        else if (r < 14) stall_left = $urandom_range(10, 25);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_byte(logic [7:0] b, bit eop, bit typed, bit terr, int gap);
    out_item_t t;
    in_valid_i <= 1'b1;
    in_data_i <= '{data_byte: b, end_of_packet: eop};
    do @(posedge clk_i); while (!in_ready_o);
    decode_byte(b, eop);
    if (typed) begin
      t = '{field_kind: K_VERDICT, field_value: '0, unit_slot: '0,
            parse_error: terr, last_of_packet: 1'b1};
      field_q.push_back(t);
    end else begin
      foreach (byte_fields[i]) field_q.push_back(byte_fields[i]);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle(int settle);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (field_q.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic set_reg(cfg_idx_e ix, logic [63:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= ix;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (ix)
      CFG_CODE:  r_code = d[7:0];
      CFG_TBITS: r_tbits = d[3:0];
      CFG_TSIZE: r_tsize = d[8:0];
      CFG_SLOTS: r_slots = d[15:0];
      CFG_FLY0:  r_fly[0] = d;
      CFG_FLY1:  r_fly[1] = d;
      CFG_FLY2:  r_fly[2] = d;
      CFG_FLY3:  r_fly[3] = d;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic setup(logic [7:0] code, logic [3:0] tb, logic [8:0] ts,
                       logic [15:0] sl, logic [63:0] f0, logic [63:0] f1,
                       logic [63:0] f2, logic [63:0] f3);
    wait_idle(90);
    set_reg(CFG_CODE, {56'd0, code});
    set_reg(CFG_TBITS, {60'd0, tb});
    set_reg(CFG_TSIZE, {55'd0, ts});
    set_reg(CFG_SLOTS, {48'd0, sl});
    set_reg(CFG_FLY0, f0);
    set_reg(CFG_FLY1, f1);
    set_reg(CFG_FLY2, f2);
    set_reg(CFG_FLY3, f3);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic put(logic [31:0] v, int w);
    for (int i = 0; i < w; i++) bits_q.push_back(v[i]);
  endtask

  // one mostly well-formed packet with random content; negative arguments but n_upd mean random
  task automatic build_pkt(int n_upd, int want_fly, int fkind, int sync_mode, int spd);
    int tmax;
    int t;
    int k;
    int c;
    int n;
    logic [7:0] f;
    bit h;
    bit fl;
    bits_q.delete();
    pkt_q.delete();
    tmax = int'(r_tsize) - 1;
    if (tmax > 255) tmax = 255;
    if (r_tbits < 8 && tmax > (1 << r_tbits) - 1) tmax = (1 << r_tbits) - 1;
    put($urandom(), 32);
    for (int u = 0; u < n_upd; u++) begin
      put($urandom_range(0, 'hfffe), 16);
      t = (tmax >= 1) ? $urandom_range(1, tmax) : 0;
      if (want_fly >= 0)
        for (int s = 1; s <= tmax; s++)
          if (r_fly[s / 64][s % 64] == want_fly[0]) t = s;
      if ($urandom_range(0, 99) < 4) t = $urandom_range(0, 1) ? 0 : tmax + 1;
      put(t, r_tbits);
      fl = r_fly[(t / 64) % 4][t % 64];
      if (fl) begin
        k = (fkind >= 0) ? fkind : (($urandom_range(0, 99) < 4) ? 3 : $urandom_range(0, 2));
        put(k, 2);
        if (k == 1) begin
          f = $urandom();
          put(f, 8);
          if (f[0]) put($urandom(), 32);
          if (f[4]) put($urandom(), 16);
          if (f[3]) put($urandom(), 16);
          if (f[6]) put($urandom(), 16);
          if (f[5]) repeat (3) put($urandom(), 32);
          put($urandom(), 2);
        end else if (k == 2) begin
          h = $urandom();
          put(h, 1);
          repeat (6) put($urandom(), 32);
          if (h) put($urandom(), 16);
          put($urandom(), 2);
        end else if (k == 0) begin
          put($urandom(), 2);
        end
      end else begin
        put($urandom(), 1);
        c = $urandom_range(0, 3);
        put(c, 2);
        repeat (c) put($urandom(), 32);
      end
    end
    put(END_INDEX, 16);
    k = (sync_mode >= 0) ? sync_mode : $urandom_range(0, 3);
    if (k == 0) begin
      put(0, 1);
    end else begin
      put(1, 1);
      if (k == 3) begin
        put(0, r_tbits);
      end else begin
        t = (tmax >= 1) ? $urandom_range(1, tmax) : 0;
        put(t, r_tbits);
        put($urandom(), 16);
        put($urandom(), 16);
        put($urandom(), 2);
        if (k == 2) begin
          put(1, 1);
          put($urandom(), 15);
          put($urandom(), 8);
        end else begin
          put(0, 1);
          repeat (3) put($urandom(), 32);
          repeat (3) put($urandom(), 16);
          if (spd > 0 || (spd < 0 && $urandom_range(0, 1))) put($urandom(), 32);
        end
      end
    end
    while (bits_q.size() % 8 != 0) bits_q.push_back(1'b0);
    n = 3 + bits_q.size() / 8;
    pkt_q.push_back(r_code);
    pkt_q.push_back(n[7:0]);
    pkt_q.push_back(n[15:8]);
    for (int i = 0; i < bits_q.size(); i += 8) begin
      for (int j = 0; j < 8; j++) f[j] = bits_q[i + j];
      pkt_q.push_back(f);
    end
  endtask

  task automatic send_pkt(bit breakable);
    int r;
    int p;
    int cut;
    cut = pkt_q.size() - 1;
    if (breakable) begin
      r = $urandom_range(0, 99);
      p = $urandom_range(0, pkt_q.size() - 1);
      if (r < 12) pkt_q[p] = pkt_q[p] ^ (8'd1 << $urandom_range(0, 7));
      else if (r < 17) cut = $urandom_range(0, pkt_q.size() - 1);
      else if (r < 22) pkt_q.push_back($urandom());
      else if (r < 26) pkt_q[1] = pkt_q[1] + 8'd1;
      cut = (r >= 17 && r < 22) ? pkt_q.size() - 1 : cut;
    end
    for (int i = 0; i <= cut; i++) send_byte(pkt_q[i], i == cut, 1'b0, 1'b0, pick_gap());
  endtask

  dir_row_t rows [12];
  int n_rand;

  initial begin
    r_code = 8'd0;
    r_tbits = 4'd0;
    r_tsize = 9'd1;
    r_slots = 16'd0;
    for (int i = 0; i < 4; i++) r_fly[i] = '0;
    clear_pkt();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // type width zero after reset rejects
    send_byte(8'h00, 1'b1, 1'b1, 1'b1, 0);

    setup(8'h5a, 4'd8, 9'd256, 16'hffff, 64'hffff_0000_ffff_0000,
          64'h0000_ffff_0000_ffff, rand64(), 64'hffff_ffff_ffff_ffff);
    rows = '{
      '{8'hff, 1'b1, 1'b1, 1'b1},
      '{8'h00, 1'b1, 1'b1, 1'b1},
      '{8'h5a, 1'b0, 1'b0, 1'b0},
      '{8'h03, 1'b0, 1'b0, 1'b0},
      '{8'h00, 1'b1, 1'b1, 1'b1},
      '{8'h5a, 1'b0, 1'b0, 1'b0},
      '{8'h03, 1'b0, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 1'b0},
      '{8'h55, 1'b1, 1'b1, 1'b1},
      '{8'h5a, 1'b0, 1'b0, 1'b0},
      '{8'h09, 1'b0, 1'b0, 1'b0},
      '{8'h00, 1'b1, 1'b1, 1'b1}
    };
    foreach (rows[i]) send_byte(rows[i].b, rows[i].eop, rows[i].typed, rows[i].terr, 0);
    send_byte(8'hff, 1'b0, 1'b0, 1'b0, 0);
    for (int i = 0; i < 4; i++) send_byte(8'hff, 1'b0, 1'b0, 1'b0, 0);
    send_byte(8'hff, 1'b1, 1'b0, 1'b0, 1);

    // mover kinds, ground path, sync variants, speed
    for (int k = 0; k < 4; k++) begin
      build_pkt(1, 1, k, 1, 1);
      send_pkt(1'b0);
    end
    build_pkt(2, 0, -1, 2, 0);
    send_pkt(1'b0);
    build_pkt(0, -1, -1, 3, 0);
    send_pkt(1'b0);
    build_pkt(0, -1, -1, 0, 0);
    send_pkt(1'b0);

    setup(8'h00, 4'd1, 9'd2, 16'd1, 64'h2, '0, '0, '0);
    build_pkt(2, -1, 1, 1, 0);
    send_pkt(1'b0);
    setup(8'hff, 4'd8, 9'd3, 16'd3, 64'h4, '0, '0, '0);
    build_pkt(1, -1, -1, 1, 1);
    send_pkt(1'b0);

    // oversize packet, swallowed after a wrong code byte
    for (int i = 0; i < 65537; i++) send_byte(8'h00, i == 65536, 1'b0, 1'b0, 0);

    // zero unit slots rejects at the first byte
    setup(8'h11, 4'd4, 9'd9, 16'd0, rand64(), rand64(), rand64(), rand64());
    send_byte(8'h11, 1'b1, 1'b1, 1'b1, 0);

    n_rand = 0;
    while (n_rand < 110) begin
      if ($urandom_range(0, 3) == 0)
        setup($urandom(), $urandom_range(1, 8), $urandom_range(1, 256),
              ($urandom_range(0, 3) == 0) ? 16'hffff : $urandom_range(1, 65535),
              rand64(), rand64(), rand64(), rand64());
      if ($urandom_range(0, 5) == 0) wait_idle(0);
      if ($urandom_range(0, 9) == 0) begin
        send_byte($urandom(), $urandom_range(0, 1), 1'b0, 1'b0, pick_gap());
        n_rand++;
      end else begin
        build_pkt($urandom_range(0, 2), -1, -1, -1, -1);
        n_rand += pkt_q.size();
        send_pkt(1'b1);
      end
    end

    wait_idle(100);
    if (n_fail == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
src/usbp_pkg.sv
src/usbp_rem.sv
src/unit_state_bitstream_parser_core.sv
tb/tb.sv
